// ===== rtl/pfe_pkg.sv =====
// Shared constants and types for the Playfair digraph encryptor.
`default_nettype none

package pfe_pkg;

   localparam int GRID_SIDE      = 5;
   localparam int CELL_COUNT     = GRID_SIDE * GRID_SIDE;
   localparam int CODE_W         = 5;
   localparam int POS_W          = $clog2(GRID_SIDE);
   localparam int IDX_W          = $clog2(CELL_COUNT);
   localparam int CELLS_PER_WORD = 12;
   localparam int WORD_W         = CELLS_PER_WORD * CODE_W;
   localparam int CSR_ADDR_W     = 2;
   localparam int TDATA_W        = 16;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   localparam csr_addr_type CSR_KEY_LOW  = csr_addr_type'(0);
   localparam csr_addr_type CSR_KEY_HIGH = csr_addr_type'(1);
   localparam csr_addr_type CSR_KEY_LAST = csr_addr_type'(2);

   // Position of one letter in the key square.
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } loc_type;

endpackage

`default_nettype wire

// ===== rtl/pfe_locate.sv =====
// Turns a cell match vector into the row and column of the first matching cell.
`default_nettype none

module pfe_locate (
   input  wire logic [pfe_pkg::CELL_COUNT-1:0] match,
   output pfe_pkg::loc_type                    loc
);

   logic [pfe_pkg::CELL_COUNT-1:0] first;

   // Keep only the lowest set bit: first match in row-major order wins.
   assign first = match & (~match + pfe_pkg::CELL_COUNT'(1));

   always_comb begin
      loc       = '0;
      loc.found = |match;
      for (int k = 0; k < pfe_pkg::CELL_COUNT; k++) begin
         if (first[k]) begin
            loc.row = loc.row | pfe_pkg::POS_W'(k / pfe_pkg::GRID_SIDE);
            loc.col = loc.col | pfe_pkg::POS_W'(k % pfe_pkg::GRID_SIDE);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/playfair_pair_encrypt.sv =====
// Top level of the Playfair digraph encryptor: four-stage pipeline and key square registers.
`default_nettype none

// Encrypts one digraph (two 5-bit letter codes) per word against a 5x5 key square
// that is loaded through the csr_ port (index 0: cells 0-11, index 1: cells 12-23,
// index 2: cell 24; cell k sits at row k/5, column k%5; the first matching cell in
// row-major order wins). Same row: each letter takes the cell to its right; same
// column: the cell below; otherwise the letters swap columns. A letter missing
// from the square gives zero ciphertext and sets rsp_tuser (not_found). The block
// takes one word per cycle while rsp_tready does not stall the output; each word
// passes through the pipeline stages (cell compare, first-match encode, target
// cell index, cell select into the output register). The first stage loads at the
// accepting edge; once the word is in the output register, rsp_tvalid stays high
// until rsp_tready takes it. A stall on the result side fills the empty stages
// first, then drops req_tready. Load the key square only while the pipeline is
// empty.

module playfair_pair_encrypt (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request: [4:0] first_letter, [9:5] second_letter, [15:10] zero
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [pfe_pkg::TDATA_W-1:0]    req_tdata,
   // response: [4:0] first_cipher, [9:5] second_cipher, [15:10] zero
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [pfe_pkg::TDATA_W-1:0]         rsp_tdata,
   // response: [0] not_found
   output logic                                rsp_tuser,
   // configuration write port
   input  wire logic                           csr_we,
   input  wire logic [pfe_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [pfe_pkg::WORD_W-1:0]     csr_wdata
);

   localparam int CW = pfe_pkg::CODE_W;
   localparam int NC = pfe_pkg::CELL_COUNT;
   localparam int PW = pfe_pkg::POS_W;
   localparam int IW = pfe_pkg::IDX_W;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] v);
      logic [PW-1:0] r;
      r = (v == PW'(pfe_pkg::GRID_SIDE - 1)) ? '0 : v + PW'(1);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Key square registers
   // ------------------------------------------------------------------
   logic [pfe_pkg::WORD_W-1:0] key_low_ff;
   logic [pfe_pkg::WORD_W-1:0] key_high_ff;
   logic [CW-1:0]              key_last_ff;
   logic [NC*CW-1:0]           key_flat;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_last_ff <= '0;
      end else if (csr_we) begin
         case (pfe_pkg::csr_addr_type'(csr_addr))
            pfe_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            pfe_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            pfe_pkg::CSR_KEY_LAST: key_last_ff <= csr_wdata[CW-1:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   assign key_flat = {key_last_ff, key_high_ff, key_low_ff};

   // ------------------------------------------------------------------
   // Stage handshake: a stage advances when it is empty or its successor
   // advances, so bubbles fill up under a stall.
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;
   logic req_fire;

   assign en4        = !v4_ff || rsp_tready;
   assign en3        = !v3_ff || en4;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_fire;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: compare both letters against every cell
   // ------------------------------------------------------------------
   logic [CW-1:0] letter_a, letter_b;
   logic [NC-1:0] match_a_in, match_b_in, match_a_ff, match_b_ff;

   assign letter_a = req_tdata[CW-1:0];
   assign letter_b = req_tdata[2*CW-1:CW];

   always_comb begin
      for (int k = 0; k < NC; k++) begin
         match_a_in[k] = (key_flat[k*CW +: CW] == letter_a);
         match_b_in[k] = (key_flat[k*CW +: CW] == letter_b);
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         match_a_ff <= match_a_in;
         match_b_ff <= match_b_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: first-match row and column of each letter
   // ------------------------------------------------------------------
   pfe_pkg::loc_type loc_a_in, loc_b_in, loc_a_ff, loc_b_ff;

   pfe_locate u_locate_a (
      .match (match_a_ff),
      .loc   (loc_a_in)
   );

   pfe_locate u_locate_b (
      .match (match_b_ff),
      .loc   (loc_b_in)
   );

   always_ff @(posedge clock) begin
      if (en2) begin
         loc_a_ff <= loc_a_in;
         loc_b_ff <= loc_b_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: apply the digraph rule and form the target cell indexes
   // ------------------------------------------------------------------
   logic [PW-1:0] xr, xc, yr, yc;
   logic [IW-1:0] tgt_a_in, tgt_b_in, tgt_a_ff, tgt_b_ff;
   logic          miss_in, miss_ff;

   always_comb begin
      if (loc_a_ff.row == loc_b_ff.row) begin
         // same row: step right, wrapping within the row
         xr = loc_a_ff.row;
         xc = wrap_inc(loc_a_ff.col);
         yr = loc_b_ff.row;
         yc = wrap_inc(loc_b_ff.col);
      end else if (loc_a_ff.col == loc_b_ff.col) begin
         // same column: step down, wrapping within the column
         xr = wrap_inc(loc_a_ff.row);
         xc = loc_a_ff.col;
         yr = wrap_inc(loc_b_ff.row);
         yc = loc_b_ff.col;
      end else begin
         // rectangle: swap columns
         xr = loc_a_ff.row;
         xc = loc_b_ff.col;
         yr = loc_b_ff.row;
         yc = loc_a_ff.col;
      end
      tgt_a_in = IW'(xr) * IW'(pfe_pkg::GRID_SIDE) + IW'(xc);
      tgt_b_in = IW'(yr) * IW'(pfe_pkg::GRID_SIDE) + IW'(yc);
      miss_in  = !(loc_a_ff.found && loc_b_ff.found);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         tgt_a_ff <= tgt_a_in;
         tgt_b_ff <= tgt_b_in;
         miss_ff  <= miss_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: select the target cells into the output register
   // ------------------------------------------------------------------
   logic [CW-1:0] ciph_a_in, ciph_b_in, ciph_a_ff, ciph_b_ff;
   logic          nf_ff;

   always_comb begin
      ciph_a_in = '0;
      ciph_b_in = '0;
      for (int k = 0; k < NC; k++) begin
         if (tgt_a_ff == IW'(k)) ciph_a_in = ciph_a_in | key_flat[k*CW +: CW];
         if (tgt_b_ff == IW'(k)) ciph_b_in = ciph_b_in | key_flat[k*CW +: CW];
      end
      if (miss_ff) begin
         ciph_a_in = '0;
         ciph_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         ciph_a_ff <= ciph_a_in;
         ciph_b_ff <= ciph_b_in;
         nf_ff     <= miss_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {(pfe_pkg::TDATA_W - 2*CW)'(0), ciph_b_ff, ciph_a_ff};
   assign rsp_tuser  = nf_ff;

`ifndef SYNTHESIS
   // A missing letter must come out as zero ciphertext.
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[2*CW-1:0] == '0))
      else $error("not_found result carries nonzero ciphertext");

   // With the output register empty, the pipeline must take a new word.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while output register is empty");

   // An accepted word must occupy the first stage on the next cycle.
   a_enter_stage1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> v1_ff)
      else $error("accepted word did not enter stage 1");
`endif

endmodule

`default_nettype wire
